### src/v4n_pkg.sv
`default_nettype none
package v4n_pkg;

   localparam int COMPONENT_WIDTH = 32;
   localparam int LANES           = 4;
   localparam int LEN_WIDTH       = COMPONENT_WIDTH + 1;
   localparam int SQ_WIDTH        = 2 * COMPONENT_WIDTH;
   localparam int SUM_WIDTH       = SQ_WIDTH + 2;
   localparam int UNIT_FRACTION   = 30;
   localparam int UNIT_WIDTH      = 32;
   localparam int QUOT_WIDTH      = UNIT_FRACTION + 1;
   localparam int REM_WIDTH       = LEN_WIDTH + 1;
   localparam int SQRT_STAGES     = LEN_WIDTH;
   localparam int DIV_STAGES      = QUOT_WIDTH;
   // abs, square, sum, root, divide, output register
   localparam int LATENCY         = 3 + SQRT_STAGES + DIV_STAGES + 1;

   typedef struct packed {
      logic signed [COMPONENT_WIDTH-1:0] x_in;
      logic signed [COMPONENT_WIDTH-1:0] y_in;
      logic signed [COMPONENT_WIDTH-1:0] z_in;
      logic signed [COMPONENT_WIDTH-1:0] w_in;
   } req_type;

   typedef struct packed {
      logic signed [UNIT_WIDTH-1:0] x_unit;
      logic signed [UNIT_WIDTH-1:0] y_unit;
      logic signed [UNIT_WIDTH-1:0] z_unit;
      logic signed [UNIT_WIDTH-1:0] w_unit;
      logic [LEN_WIDTH-1:0]         length;
      logic                         zero_vector;
   } rsp_type;

   // values that ride alongside the square root
   typedef struct packed {
      logic [LANES-1:0][COMPONENT_WIDTH-1:0] mag;
      logic [LANES-1:0]                      neg;
      logic                                  zero;
   } side_type;

   // what the merge stage needs next to the lane quotients
   typedef struct packed {
      logic                 valid;
      logic                 zero;
      logic [LEN_WIDTH-1:0] len;
   } tag_type;

endpackage
`default_nettype wire

### src/v4n_sqrt.sv
`default_nettype none
module v4n_sqrt
   import v4n_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire logic [SUM_WIDTH-1:0] in_sum,
   input  wire side_type             in_side,
   output logic                      out_valid,
   output logic [LEN_WIDTH-1:0]      out_root,
   output side_type                  out_side
);

   // restoring root, one result bit per stage, MSB first
   logic                 valid_ff [SQRT_STAGES];
   logic [SUM_WIDTH-1:0] rem_ff   [SQRT_STAGES];
   logic [LEN_WIDTH-1:0] root_ff  [SQRT_STAGES];
   side_type             side_ff  [SQRT_STAGES];

   for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
      localparam int B = SQRT_STAGES - 1 - k;
      logic                 valid_prev;
      logic [SUM_WIDTH-1:0] rem_prev;
      logic [LEN_WIDTH-1:0] root_prev;
      side_type             side_prev;
      logic [SUM_WIDTH:0]   trial;
      logic                 take;
      logic [SUM_WIDTH-1:0] rem_in;
      logic [LEN_WIDTH-1:0] root_in;

      if (k == 0) begin : g_first
         assign valid_prev = in_valid;
         assign rem_prev   = in_sum;
         assign root_prev  = '0;
         assign side_prev  = in_side;
      end else begin : g_next
         assign valid_prev = valid_ff[k-1];
         assign rem_prev   = rem_ff[k-1];
         assign root_prev  = root_ff[k-1];
         assign side_prev  = side_ff[k-1];
      end

      // (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B), bits do not overlap
      assign trial   = ((SUM_WIDTH+1)'(root_prev) << (B + 1))
                     | ((SUM_WIDTH+1)'(1) << (2 * B));
      assign take    = {1'b0, rem_prev} >= trial;
      assign rem_in  = take ? rem_prev - trial[SUM_WIDTH-1:0] : rem_prev;
      assign root_in = take ? root_prev | (LEN_WIDTH'(1) << B) : root_prev;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_prev;
         end
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
         side_ff[k] <= side_prev;
      end
   end

   assign out_valid = valid_ff[SQRT_STAGES-1];
   assign out_root  = root_ff[SQRT_STAGES-1];
   assign out_side  = side_ff[SQRT_STAGES-1];

endmodule
`default_nettype wire

### src/v4n_div_lane.sv
`default_nettype none
module v4n_div_lane
   import v4n_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic [COMPONENT_WIDTH-1:0] in_mag,
   input  wire logic                       in_neg,
   input  wire logic [LEN_WIDTH-1:0]       in_div,
   output logic [QUOT_WIDTH-1:0]           out_quot,
   output logic                            out_neg
);

   // mag * 2^30 / div, mag <= div, one quotient bit per stage
   logic [REM_WIDTH-1:0]  rem_ff  [DIV_STAGES];
   logic [LEN_WIDTH-1:0]  div_ff  [DIV_STAGES];
   logic [QUOT_WIDTH-1:0] quot_ff [DIV_STAGES];
   logic                  neg_ff  [DIV_STAGES];

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      logic [REM_WIDTH-1:0]  rem_prev;
      logic [LEN_WIDTH-1:0]  div_prev;
      logic [QUOT_WIDTH-1:0] quot_prev;
      logic                  neg_prev;
      logic                  take;
      logic [REM_WIDTH-1:0]  diff;
      logic [REM_WIDTH-1:0]  rem_in;

      if (k == 0) begin : g_first
         assign rem_prev  = REM_WIDTH'(in_mag);
         assign div_prev  = in_div;
         assign quot_prev = '0;
         assign neg_prev  = in_neg;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign div_prev  = div_ff[k-1];
         assign quot_prev = quot_ff[k-1];
         assign neg_prev  = neg_ff[k-1];
      end

      assign take   = rem_prev >= REM_WIDTH'(div_prev);
      assign diff   = take ? rem_prev - REM_WIDTH'(div_prev) : rem_prev;
      // remainder stays below the divisor, so it fits before the shift
      assign rem_in = {diff[LEN_WIDTH-1:0], 1'b0};

      always_ff @(posedge clock) begin
         rem_ff[k]  <= rem_in;
         div_ff[k]  <= div_prev;
         quot_ff[k] <= {quot_prev[QUOT_WIDTH-2:0], take};
         neg_ff[k]  <= neg_prev;
      end
   end

   assign out_quot = quot_ff[DIV_STAGES-1];
   assign out_neg  = neg_ff[DIV_STAGES-1];

endmodule
`default_nettype wire

### src/vector4_normalize.sv
// vector4_normalize: takes a four-component signed Q16.16 vector per transfer
// and returns the unit vector in signed Q2.30 plus the magnitude in unsigned
// Q17.16 (rounded down). A zero vector gives zero outputs with zero_vector set.
// The block is fully pipelined: busy is always low, a new vector may be
// started every clock, and each result appears on rsp_data with rsp_valid
// high for exactly one cycle. The pipeline is built from the bit-serial
// units: 33 square-root stages (one per magnitude bit) and 31 divider
// stages (one per quotient bit), plus absolute value, squaring, summing
// and the output register. The receiver cannot stall; results must be
// captured in the cycle they are strobed. No configuration, no state
// carried between vectors.
`default_nettype none
module vector4_normalize
   import v4n_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   logic [LANES-1:0][COMPONENT_WIDTH-1:0] raw;

   // stage 1: magnitudes and signs
   logic                                  valid1_ff;
   logic [LANES-1:0][COMPONENT_WIDTH-1:0] mag1_ff;
   logic [LANES-1:0]                      neg1_ff;
   // stage 2: squares
   logic                                  valid2_ff;
   logic [LANES-1:0][SQ_WIDTH-1:0]        sq2_ff;
   side_type                              side2_ff;
   // stage 3: sum of squares
   logic                                  valid3_ff;
   logic [SUM_WIDTH-1:0]                  sum3_ff;
   side_type                              side3_ff;

   logic                 root_valid;
   logic [LEN_WIDTH-1:0] root;
   side_type             root_side;

   logic [LANES-1:0][QUOT_WIDTH-1:0] quot;
   logic [LANES-1:0]                 quot_neg;
   tag_type                          tag_ff [DIV_STAGES];

   logic [LANES-1:0][UNIT_WIDTH-1:0] unit;
   rsp_type                          rsp_in;
   logic                             rsp_valid_ff;
   rsp_type                          rsp_data_ff;

   assign busy = 1'b0;
   assign raw  = {req_data.x_in, req_data.y_in, req_data.z_in, req_data.w_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         valid1_ff <= start;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
      end
      for (int i = 0; i < LANES; i++) begin
         neg1_ff[i] <= raw[i][COMPONENT_WIDTH-1];
         // most negative value maps to 2^(w-1), which still fits unsigned
         mag1_ff[i] <= raw[i][COMPONENT_WIDTH-1] ? ~raw[i] + 1'b1 : raw[i];
         sq2_ff[i]  <= SQ_WIDTH'(mag1_ff[i]) * SQ_WIDTH'(mag1_ff[i]);
      end
      side2_ff.mag  <= mag1_ff;
      side2_ff.neg  <= neg1_ff;
      side2_ff.zero <= mag1_ff == '0;
      sum3_ff <= SUM_WIDTH'(sq2_ff[0]) + SUM_WIDTH'(sq2_ff[1])
               + SUM_WIDTH'(sq2_ff[2]) + SUM_WIDTH'(sq2_ff[3]);
      side3_ff <= side2_ff;
   end

   v4n_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid3_ff),
      .in_sum    (sum3_ff),
      .in_side   (side3_ff),
      .out_valid (root_valid),
      .out_root  (root),
      .out_side  (root_side)
   );

   // one divider lane per component, all sharing the magnitude
   for (genvar i = 0; i < LANES; i++) begin : g_lane
      v4n_div_lane u_lane (
         .clock    (clock),
         .in_mag   (root_side.mag[i]),
         .in_neg   (root_side.neg[i]),
         .in_div   (root),
         .out_quot (quot[i]),
         .out_neg  (quot_neg[i])
      );
   end

   // valid, zero flag and magnitude follow the lanes
   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_tag
      tag_type tag_prev;
      if (k == 0) begin : g_first
         assign tag_prev = '{valid: root_valid, zero: root_side.zero, len: root};
      end else begin : g_next
         assign tag_prev = tag_ff[k-1];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[k].valid <= 1'b0;
         end else begin
            tag_ff[k].valid <= tag_prev.valid;
         end
         tag_ff[k].zero <= tag_prev.zero;
         tag_ff[k].len  <= tag_prev.len;
      end
   end

   // merge: apply signs, blank a zero vector (its divide ran by zero)
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         unit[i] = quot_neg[i] ? ~UNIT_WIDTH'(quot[i]) + 1'b1 : UNIT_WIDTH'(quot[i]);
         if (tag_ff[DIV_STAGES-1].zero) begin
            unit[i] = '0;
         end
      end
      rsp_in.x_unit      = unit[3];
      rsp_in.y_unit      = unit[2];
      rsp_in.z_unit      = unit[1];
      rsp_in.w_unit      = unit[0];
      rsp_in.length      = tag_ff[DIV_STAGES-1].zero ? '0 : tag_ff[DIV_STAGES-1].len;
      rsp_in.zero_vector = tag_ff[DIV_STAGES-1].zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= tag_ff[DIV_STAGES-1].valid;
      end
      rsp_data_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

### src/v4n_checker.sv
`default_nettype none
module v4n_checker
   import v4n_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire rsp_type rsp_data
);

   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##LATENCY rsp_valid)
      else $error("result missing after start");

   a_zero_outputs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_vector |->
         rsp_data.x_unit == 0 && rsp_data.y_unit == 0 && rsp_data.z_unit == 0
         && rsp_data.w_unit == 0 && rsp_data.length == 0)
      else $error("zero vector with nonzero outputs");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_data.x_unit <= 32'sd1073741824 && rsp_data.x_unit >= -32'sd1073741824
         && rsp_data.y_unit <= 32'sd1073741824 && rsp_data.y_unit >= -32'sd1073741824
         && rsp_data.z_unit <= 32'sd1073741824 && rsp_data.z_unit >= -32'sd1073741824
         && rsp_data.w_unit <= 32'sd1073741824 && rsp_data.w_unit >= -32'sd1073741824)
      else $error("unit component out of range");

endmodule

bind vector4_normalize v4n_checker u_v4n_checker (.*);
`default_nettype wire

### test/vector4_normalize_tb.sv
module vector4_normalize_tb;
   import v4n_pkg::*;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // block ports
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   vector4_normalize i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // vectors waiting to be sent, and unit vectors waiting to come back
   req_type vec_pending[$];
   rsp_type unit_expected[$];

   int  send_idle_pct = 13;   // percent of cycles the sender holds back
   bit  hold_sends     = 1'b0; // sender holds back while this is set
   int  mismatches     = 0;
   bit  stray          = 1'b0;
   longint cycles      = 0;

   // floor(sqrt(n)), bit by bit from the top; n fits 66 bits
   function automatic logic [LEN_WIDTH-1:0] isqrt(logic [SUM_WIDTH-1:0] n);
      logic [LEN_WIDTH-1:0] r;
      logic [LEN_WIDTH-1:0] t;
      logic [2*LEN_WIDTH-1:0] sq;
      r = '0;
      for (int b = LEN_WIDTH-1; b >= 0; b--) begin
         t  = r | (LEN_WIDTH'(1) << b);
         sq = t * t;
         if (sq <= n) r = t;
      end
      return r;
   endfunction

   // predicted unit vector and magnitude for one input vector
   function automatic rsp_type normalize(req_type v);
      logic signed [COMPONENT_WIDTH-1:0] comp[4];
      logic [COMPONENT_WIDTH:0]   mag[4];   // one extra bit holds |-2^31|
      logic [SUM_WIDTH-1:0]       sumsq;
      logic [LEN_WIDTH-1:0]       len;
      logic [63:0]                q;
      logic [UNIT_WIDTH-1:0]      u[4];
      rsp_type r;
      comp[0] = v.x_in; comp[1] = v.y_in; comp[2] = v.z_in; comp[3] = v.w_in;
      sumsq = '0;
      for (int i = 0; i < 4; i++) begin
         mag[i] = comp[i][COMPONENT_WIDTH-1] ? (-{comp[i][COMPONENT_WIDTH-1], comp[i]})
                                             : {1'b0, comp[i]};
         sumsq += SUM_WIDTH'(mag[i]) * SUM_WIDTH'(mag[i]);
      end
      r = '0;
      if (sumsq == 0) begin
         r.zero_vector = 1'b1;
         return r;
      end
      len = isqrt(sumsq);
      for (int i = 0; i < 4; i++) begin
         q    = (64'(mag[i]) << UNIT_FRACTION) / 64'(len);
         u[i] = comp[i][COMPONENT_WIDTH-1] ? -q[UNIT_WIDTH-1:0] : q[UNIT_WIDTH-1:0];
      end
      r.x_unit = u[0]; r.y_unit = u[1]; r.z_unit = u[2]; r.w_unit = u[3];
      r.length = len;
      return r;
   endfunction

   // driver: start is updated once per edge; a transfer happens when start
   // and not busy are seen at an edge
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            unit_expected.push_back(normalize(req_data));
            void'(vec_pending.pop_front());
         end
         if (vec_pending.size() > 0 && !hold_sends
             && $urandom_range(99) >= send_idle_pct) begin
            start    <= 1'b1;
            req_data <= vec_pending[0];
         end else if (!(start && busy)) begin
            start <= 1'b0;
         end
      end
   end
   // note: when start was high and busy low, the head was popped above, so
   // the new head (if any) is what gets presented next

   // monitor: every strobed result is checked against the oldest prediction
   always @(posedge clock) begin
      rsp_type e;
      cycles <= cycles + 1;
      if (!reset && rsp_valid) begin
         if (unit_expected.size() == 0) begin
            stray = 1'b1;
            mismatches++;
            if (mismatches <= 10) $display("unexpected transfer: %h", rsp_data);
         end else begin
            e = unit_expected.pop_front();
            if (e !== rsp_data) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp x=%h y=%h z=%h w=%h len=%h zero=%b\n"
                           , e.x_unit, e.y_unit, e.z_unit, e.w_unit, e.length
                           , e.zero_vector,
                           "          got x=%h y=%h z=%h w=%h len=%h zero=%b",
                           rsp_data.x_unit, rsp_data.y_unit, rsp_data.z_unit,
                           rsp_data.w_unit, rsp_data.length, rsp_data.zero_vector);
            end
         end
      end
   end

   // timeout
   always @(posedge clock) begin
      if (cycles > 200000) begin
         $display("** vector4_normalize: FAILED **");
         $finish;
      end
   end

   localparam logic signed [31:0] MAXP = 32'sh7fffffff;
   localparam logic signed [31:0] MAXN = 32'sh80000000;

   function automatic logic [31:0] rand_comp();
      case ($urandom_range(5))
         0: return 32'($urandom_range(3)) - 32'd1;
         1: return $urandom_range(1) ? MAXP : MAXN;
         2: return 32'($signed($urandom_range(65535)) - 32768);
         default: return $urandom;
      endcase
   endfunction

   task automatic add_vec(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [31:0] w);
      req_type v;
      v.x_in = x; v.y_in = y; v.z_in = z; v.w_in = w;
      vec_pending.push_back(v);
   endtask

   task automatic add_random(int n);
      for (int i = 0; i < n; i++)
         add_vec(rand_comp(), rand_comp(), rand_comp(), rand_comp());
   endtask

   task automatic drain();
      while (vec_pending.size() != 0 || start) @(posedge clock);
      while (unit_expected.size() != 0) @(posedge clock);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: zero vector, single axes, extremes, most negative value
      add_vec(0, 0, 0, 0);
      add_vec(32'h10000, 0, 0, 0);
      add_vec(0, -32'sh10000, 0, 0);
      add_vec(0, 0, 1, 0);
      add_vec(0, 0, 0, MAXN);
      add_vec(MAXN, MAXN, MAXN, MAXN);
      add_vec(MAXP, MAXP, MAXP, MAXP);
      add_vec(MAXP, MAXN, MAXP, MAXN);
      add_vec(1, 1, 1, 1);
      add_vec(-1, -1, -1, -1);
      add_vec(32'h30000, 32'h40000, 0, 0);
      add_vec(1, 0, 0, MAXP);
      add_vec(32'hffffffff, 0, 0, 0);
      add_vec(0, 0, 0, 0);
      add_vec(32'h55555555, 32'haaaaaaaa, 32'h12345678, 32'hedcba987);

      // phase one: sender idles 13 percent
      add_random(170);
      drain();

      // pause with nothing in flight, then sender idles 60 percent
      hold_sends    = 1'b1;
      repeat (5) @(posedge clock);
      send_idle_pct = 60;
      hold_sends    = 1'b0;
      add_random(180);
      drain();

      // back to back
      send_idle_pct = 0;
      add_random(185);
      drain();

      repeat (LATENCY + 20) @(posedge clock);
      if (mismatches == 0 && !stray)
         $display("** vector4_normalize: PASSED **");
      else
         $display("** vector4_normalize: FAILED **");
      $finish;
   end

endmodule

### filelist.f
src/v4n_pkg.sv
src/v4n_sqrt.sv
src/v4n_div_lane.sv
src/vector4_normalize.sv
src/v4n_checker.sv
test/vector4_normalize_tb.sv
